[sv/line_rasterizer_unit_assert.svh]
// Assertion macros for the line rasterizer.
// Define NO_ASSERTIONS to compile them out.
`ifndef LINE_RASTERIZER_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check while out of reset.
`define LR_ASSERT_ON(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("line rasterizer check failed");
// Check at every edge, reset included.
`define LR_ASSERT_AT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("line rasterizer reset check failed");
`else
`define LR_ASSERT_ON(label, clk, rstn, prop)
`define LR_ASSERT_AT_RESET(label, clk, prop)
`endif
`endif

[sv/lr_pkg.sv]
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int OFFSET_W   = 12;
    localparam int BPP_W      = 3;
    localparam int PITCH_W    = 14;
    localparam int SHIFT_W    = 5;
    localparam int CHAN_W     = 8;
    localparam int ADDR_W     = 27;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET        = 3'd0,
        REG_Y_OFFSET        = 3'd1,
        REG_BYTES_PER_PIXEL = 3'd2,
        REG_LINE_PITCH      = 3'd3,
        REG_RED_SHIFT       = 3'd4,
        REG_GREEN_SHIFT     = 3'd5,
        REG_BLUE_SHIFT      = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } func_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] x_offset;
        logic [OFFSET_W-1:0] y_offset;
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [PITCH_W-1:0]  line_pitch;
        logic [SHIFT_W-1:0]  red_shift;
        logic [SHIFT_W-1:0]  green_shift;
        logic [SHIFT_W-1:0]  blue_shift;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        x_offset:        12'd0,
        y_offset:        12'd0,
        bytes_per_pixel: 3'd4,
        line_pitch:      14'd7680,
        red_shift:       5'd16,
        green_shift:     5'd8,
        blue_shift:      5'd0
    };

    typedef struct packed {
        logic in_valid;
        logic line_active;
        logic emit;
        logic emit_last;
    } status_t;

endpackage

`default_nettype wire

[sv/lr_config.sv]
`default_nettype none

module lr_config (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lr_pkg::CFG_DATA_W-1:0] cfg_data,
    output lr_pkg::cfg_t                       cfg
);

    lr_pkg::cfg_t cfg_reg;
    lr_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (lr_pkg::cfg_idx_t'(cfg_index))
                lr_pkg::REG_X_OFFSET: begin
                    cfg_next.x_offset = cfg_data[lr_pkg::OFFSET_W-1:0];
                end
                lr_pkg::REG_Y_OFFSET: begin
                    cfg_next.y_offset = cfg_data[lr_pkg::OFFSET_W-1:0];
                end
                lr_pkg::REG_BYTES_PER_PIXEL: begin
                    cfg_next.bytes_per_pixel = cfg_data[lr_pkg::BPP_W-1:0];
                end
                lr_pkg::REG_LINE_PITCH: begin
                    cfg_next.line_pitch = cfg_data[lr_pkg::PITCH_W-1:0];
                end
                lr_pkg::REG_RED_SHIFT: begin
                    cfg_next.red_shift = cfg_data[lr_pkg::SHIFT_W-1:0];
                end
                lr_pkg::REG_GREEN_SHIFT: begin
                    cfg_next.green_shift = cfg_data[lr_pkg::SHIFT_W-1:0];
                end
                lr_pkg::REG_BLUE_SHIFT: begin
                    cfg_next.blue_shift = cfg_data[lr_pkg::SHIFT_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= lr_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/lr_stepper.sv]
`default_nettype none

module lr_stepper #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_func,
    input  wire logic [COORD_BITS-1:0]       s_start_x,
    input  wire logic [COORD_BITS-1:0]       s_start_y,
    input  wire logic [COORD_BITS-1:0]       s_end_x,
    input  wire logic [COORD_BITS-1:0]       s_end_y,
    input  wire logic [lr_pkg::CHAN_W-1:0]   s_red,
    input  wire logic [lr_pkg::CHAN_W-1:0]   s_green,
    input  wire logic [lr_pkg::CHAN_W-1:0]   s_blue,
    input  wire lr_pkg::cfg_t                cfg,
    output logic                             px_valid,
    input  wire logic                        px_ready,
    output logic [COORD_BITS-1:0]            px_x,
    output logic [COORD_BITS-1:0]            px_y,
    output logic [lr_pkg::WORD_W-1:0]        px_color,
    output logic                             px_last,
    output lr_pkg::status_t                  status
);

    localparam int SPAN_W = COORD_BITS + 1;
    localparam int TERM_W = COORD_BITS + 3;

    // input register
    logic                      in_valid_reg, in_valid_next;
    lr_pkg::func_t             in_func_reg;
    logic [COORD_BITS-1:0]     in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic [lr_pkg::CHAN_W-1:0] in_red_reg, in_green_reg, in_blue_reg;

    // line state
    logic [COORD_BITS-1:0]     major_pos_reg, major_pos_next;
    logic [COORD_BITS-1:0]     minor_pos_reg, minor_pos_next;
    logic signed [TERM_W-1:0]  decision_term_reg, decision_term_next;
    logic [SPAN_W-1:0]         pixels_left_reg, pixels_left_next;
    logic                      step_down_reg, step_down_next;
    logic                      steep_reg, steep_next;
    logic [SPAN_W-1:0]         major_span_reg, major_span_next;
    logic [SPAN_W-1:0]         minor_span_reg, minor_span_next;
    logic [lr_pkg::WORD_W-1:0] packed_color_reg, packed_color_next;

    // pixel register
    logic                      p_valid_reg, p_valid_next;
    logic [COORD_BITS-1:0]     p_x_reg, p_y_reg;
    logic [lr_pkg::WORD_W-1:0] p_color_reg;
    logic                      p_last_reg;

    logic                      p_ready_int;
    logic                      in_fire;
    logic                      do_load;
    logic                      emit;
    logic                      active;
    logic                      last_px;
    logic                      d_pos;
    logic [COORD_BITS-1:0]     adx, ady;
    logic                      shallow, swap, load_down;
    logic [COORD_BITS-1:0]     load_maj0, load_min0;
    logic [SPAN_W-1:0]         load_maj_span, load_min_span;
    logic signed [TERM_W-1:0]  load_term;
    logic [lr_pkg::WORD_W-1:0] red_ext, green_ext, blue_ext, load_color;
    logic signed [TERM_W-1:0]  step_term;
    logic [COORD_BITS-1:0]     sel_x, sel_y;

    assign p_ready_int = !p_valid_reg || px_ready;
    assign s_ready     = !in_valid_reg || p_ready_int;
    assign in_fire     = in_valid_reg && p_ready_int;
    assign active      = pixels_left_reg != '0;
    assign last_px     = pixels_left_reg == SPAN_W'(1);
    assign d_pos       = !decision_term_reg[TERM_W-1] && (decision_term_reg != '0);
    assign do_load     = in_fire && (in_func_reg == lr_pkg::FUNC_LOAD);
    assign emit        = in_fire && (in_func_reg == lr_pkg::FUNC_STEP) && active;
    assign sel_x       = steep_reg ? minor_pos_reg : major_pos_reg;
    assign sel_y       = steep_reg ? major_pos_reg : minor_pos_reg;

    // line setup: order endpoints along the major axis
    always_comb begin
        adx = (in_ex_reg >= in_sx_reg) ? in_ex_reg - in_sx_reg : in_sx_reg - in_ex_reg;
        ady = (in_ey_reg >= in_sy_reg) ? in_ey_reg - in_sy_reg : in_sy_reg - in_ey_reg;
        shallow = ady < adx;
        if (shallow) begin
            swap          = in_sx_reg > in_ex_reg;
            load_maj0     = swap ? in_ex_reg : in_sx_reg;
            load_min0     = swap ? in_ey_reg : in_sy_reg;
            load_down     = swap ? (in_sy_reg < in_ey_reg) : (in_ey_reg < in_sy_reg);
            load_maj_span = SPAN_W'(adx);
            load_min_span = SPAN_W'(ady);
        end else begin
            swap          = in_sy_reg > in_ey_reg;
            load_maj0     = swap ? in_ey_reg : in_sy_reg;
            load_min0     = swap ? in_ex_reg : in_sx_reg;
            load_down     = swap ? (in_sx_reg < in_ex_reg) : (in_ex_reg < in_sx_reg);
            load_maj_span = SPAN_W'(ady);
            load_min_span = SPAN_W'(adx);
        end
        load_term = $signed({1'b0, load_min_span, 1'b0}) - $signed({2'b00, load_maj_span});

        red_ext    = lr_pkg::WORD_W'(in_red_reg);
        green_ext  = lr_pkg::WORD_W'(in_green_reg);
        blue_ext   = lr_pkg::WORD_W'(in_blue_reg);
        load_color = (red_ext << cfg.red_shift) | (green_ext << cfg.green_shift)
                   | (blue_ext << cfg.blue_shift);
    end

    // one Bresenham step
    always_comb begin
        step_term = decision_term_reg + $signed({1'b0, minor_span_reg, 1'b0});
        if (d_pos) begin
            step_term = step_term - $signed({1'b0, major_span_reg, 1'b0});
        end
    end

    always_comb begin
        in_valid_next      = s_ready ? s_valid : in_valid_reg;
        major_pos_next     = major_pos_reg;
        minor_pos_next     = minor_pos_reg;
        decision_term_next = decision_term_reg;
        pixels_left_next   = pixels_left_reg;
        step_down_next     = step_down_reg;
        steep_next         = steep_reg;
        major_span_next    = major_span_reg;
        minor_span_next    = minor_span_reg;
        packed_color_next  = packed_color_reg;
        if (do_load) begin
            major_pos_next     = load_maj0;
            minor_pos_next     = load_min0;
            decision_term_next = load_term;
            pixels_left_next   = load_maj_span;
            step_down_next     = load_down;
            steep_next         = !shallow;
            major_span_next    = load_maj_span;
            minor_span_next    = load_min_span;
            packed_color_next  = load_color;
        end else if (emit) begin
            if (d_pos) begin
                minor_pos_next = step_down_reg ? minor_pos_reg - COORD_BITS'(1)
                                               : minor_pos_reg + COORD_BITS'(1);
            end
            decision_term_next = step_term;
            major_pos_next     = major_pos_reg + COORD_BITS'(1);
            pixels_left_next   = pixels_left_reg - SPAN_W'(1);
        end
        p_valid_next = p_ready_int ? emit : p_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            pixels_left_reg <= '0;
            p_valid_reg     <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            pixels_left_reg <= pixels_left_next;
            p_valid_reg     <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        major_pos_reg     <= major_pos_next;
        minor_pos_reg     <= minor_pos_next;
        decision_term_reg <= decision_term_next;
        step_down_reg     <= step_down_next;
        steep_reg         <= steep_next;
        major_span_reg    <= major_span_next;
        minor_span_reg    <= minor_span_next;
        packed_color_reg  <= packed_color_next;
        if (s_valid && s_ready) begin
            in_func_reg  <= lr_pkg::func_t'(s_func);
            in_sx_reg    <= s_start_x;
            in_sy_reg    <= s_start_y;
            in_ex_reg    <= s_end_x;
            in_ey_reg    <= s_end_y;
            in_red_reg   <= s_red;
            in_green_reg <= s_green;
            in_blue_reg  <= s_blue;
        end
        if (p_ready_int) begin
            p_x_reg     <= sel_x;
            p_y_reg     <= sel_y;
            p_color_reg <= packed_color_reg;
            p_last_reg  <= last_px;
        end
    end

    assign px_valid = p_valid_reg;
    assign px_x     = p_x_reg;
    assign px_y     = p_y_reg;
    assign px_color = p_color_reg;
    assign px_last  = p_last_reg;

    assign status.in_valid    = in_valid_reg;
    assign status.line_active = active;
    assign status.emit        = emit;
    assign status.emit_last   = emit && last_px;

endmodule

`default_nettype wire

[sv/lr_address.sv]
`default_nettype none

module lr_address #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lr_pkg::cfg_t                cfg,
    input  wire logic                        px_valid,
    output logic                             px_ready,
    input  wire logic [COORD_BITS-1:0]       px_x,
    input  wire logic [COORD_BITS-1:0]       px_y,
    input  wire logic [lr_pkg::WORD_W-1:0]   px_color,
    input  wire logic                        px_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [COORD_BITS-1:0]            m_pixel_x,
    output logic [COORD_BITS-1:0]            m_pixel_y,
    output logic [lr_pkg::ADDR_W-1:0]        m_byte_address,
    output logic [lr_pkg::WORD_W-1:0]        m_pixel_word,
    output logic                             m_last
);

    localparam int SUM_W = ((COORD_BITS > lr_pkg::OFFSET_W) ? COORD_BITS
                                                            : lr_pkg::OFFSET_W) + 1;
    localparam int PX_W  = SUM_W + lr_pkg::BPP_W;
    localparam int PY_W  = SUM_W + lr_pkg::PITCH_W;

    // product stage
    logic                      q_valid_reg, q_valid_next;
    logic [lr_pkg::ADDR_W-1:0] q_prod_x_reg, q_prod_y_reg;
    logic [COORD_BITS-1:0]     q_x_reg, q_y_reg;
    logic [lr_pkg::WORD_W-1:0] q_color_reg;
    logic                      q_last_reg;

    // output register
    logic                      o_valid_reg, o_valid_next;
    logic [COORD_BITS-1:0]     o_x_reg, o_y_reg;
    logic [lr_pkg::ADDR_W-1:0] o_addr_reg;
    logic [lr_pkg::WORD_W-1:0] o_color_reg;
    logic                      o_last_reg;

    logic                      o_ready, q_ready;
    logic [SUM_W-1:0]          x_sum, y_sum;
    logic [PX_W-1:0]           prod_x_full;
    logic [PY_W-1:0]           prod_y_full;
    logic [lr_pkg::ADDR_W-1:0] addr_sum;

    assign o_ready  = !o_valid_reg || m_ready;
    assign q_ready  = !q_valid_reg || o_ready;
    assign px_ready = q_ready;

    always_comb begin
        x_sum        = SUM_W'(px_x) + SUM_W'(cfg.x_offset);
        y_sum        = SUM_W'(px_y) + SUM_W'(cfg.y_offset);
        prod_x_full  = PX_W'(x_sum) * PX_W'(cfg.bytes_per_pixel);
        prod_y_full  = PY_W'(y_sum) * PY_W'(cfg.line_pitch);
        // address wraps at its field width
        addr_sum     = q_prod_x_reg + q_prod_y_reg;
        q_valid_next = q_ready ? px_valid : q_valid_reg;
        o_valid_next = o_ready ? q_valid_reg : o_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= q_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready) begin
            q_prod_x_reg <= lr_pkg::ADDR_W'(prod_x_full);
            q_prod_y_reg <= lr_pkg::ADDR_W'(prod_y_full);
            q_x_reg      <= px_x;
            q_y_reg      <= px_y;
            q_color_reg  <= px_color;
            q_last_reg   <= px_last;
        end
        if (o_ready) begin
            o_x_reg     <= q_x_reg;
            o_y_reg     <= q_y_reg;
            o_addr_reg  <= addr_sum;
            o_color_reg <= q_color_reg;
            o_last_reg  <= q_last_reg;
        end
    end

    assign m_valid        = o_valid_reg;
    assign m_pixel_x      = o_x_reg;
    assign m_pixel_y      = o_y_reg;
    assign m_byte_address = o_addr_reg;
    assign m_pixel_word   = o_color_reg;
    assign m_last         = o_last_reg;

endmodule

`default_nettype wire

[sv/line_rasterizer_unit.sv]
`default_nettype none

// Bresenham line rasterizer. A load word (tuser low) sets up a line from two
// endpoints and a colour and gives no output; each step word (tuser high) gives
// one pixel with its coordinates, framebuffer byte offset and packed colour,
// with tlast on the final pixel. The endpoint with the larger major-axis
// coordinate is not drawn, and a step with no line active is taken and dropped.
// While m_tready does not hold the output back, the block takes one word every
// clock and gives one pixel per clock: the rate is set by the decision-term
// update in the stepper. A step word lands in the input register when it is
// taken, then passes the pixel register, the address product register and the
// output register. Write configuration only while no word is in flight; the
// colour is packed with the shift settings present at load.

`include "line_rasterizer_unit_assert.svh"

module line_rasterizer_unit #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
    localparam int S_DATA_W  = ((4 * COORD_BITS + 3 * lr_pkg::CHAN_W + 7) / 8) * 8,
    localparam int M_RAW_W   = 2 * COORD_BITS + lr_pkg::ADDR_W + lr_pkg::WORD_W,
    localparam int M_DATA_W  = ((M_RAW_W + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, end_x, end_y, red, green, blue
    input  wire logic [S_DATA_W-1:0]           s_tdata,
    // func
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pixel_x, pixel_y, byte_address, pixel_word
    output logic [M_DATA_W-1:0]                m_tdata,
    output logic                               m_tlast,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lr_pkg::CFG_DATA_W-1:0] cfg_data
);

    lr_pkg::cfg_t              cfg;
    lr_pkg::status_t           st;
    logic                      px_valid, px_ready, px_last;
    logic [COORD_BITS-1:0]     px_x, px_y;
    logic [lr_pkg::WORD_W-1:0] px_color;
    logic [COORD_BITS-1:0]     out_x, out_y;
    logic [lr_pkg::ADDR_W-1:0] out_addr;
    logic [lr_pkg::WORD_W-1:0] out_word;

    lr_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lr_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_func    (s_tuser),
        .s_start_x (s_tdata[0 * COORD_BITS +: COORD_BITS]),
        .s_start_y (s_tdata[1 * COORD_BITS +: COORD_BITS]),
        .s_end_x   (s_tdata[2 * COORD_BITS +: COORD_BITS]),
        .s_end_y   (s_tdata[3 * COORD_BITS +: COORD_BITS]),
        .s_red     (s_tdata[4 * COORD_BITS +: lr_pkg::CHAN_W]),
        .s_green   (s_tdata[4 * COORD_BITS + lr_pkg::CHAN_W +: lr_pkg::CHAN_W]),
        .s_blue    (s_tdata[4 * COORD_BITS + 2 * lr_pkg::CHAN_W +: lr_pkg::CHAN_W]),
        .cfg       (cfg),
        .px_valid  (px_valid),
        .px_ready  (px_ready),
        .px_x      (px_x),
        .px_y      (px_y),
        .px_color  (px_color),
        .px_last   (px_last),
        .status    (st)
    );

    lr_address #(
        .COORD_BITS (COORD_BITS)
    ) u_address (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .px_valid       (px_valid),
        .px_ready       (px_ready),
        .px_x           (px_x),
        .px_y           (px_y),
        .px_color       (px_color),
        .px_last        (px_last),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_pixel_x      (out_x),
        .m_pixel_y      (out_y),
        .m_byte_address (out_addr),
        .m_pixel_word   (out_word),
        .m_last         (m_tlast)
    );

    assign m_tdata = M_DATA_W'({out_word, out_addr, out_y, out_x});

    `LR_ASSERT_AT_RESET(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `LR_ASSERT_ON(a_last_ends_line, aclk, aresetn, st.emit_last |=> !st.line_active)
    `LR_ASSERT_ON(a_emit_fills_pixel, aclk, aresetn, st.emit |=> px_valid)

endmodule

`default_nettype wire
